[rtl/ple_pkg.sv]
// Shared types, codes and widths for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ACT_W     = 2;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int ST_W      = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic take;
        logic rd;
        logic wr;
        logic put;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    err;
        logic    more;
        logic    hit;
        logic    out_free;
    } t_stat;

endpackage

[rtl/ple_req_if.sv]
// Request channel interface: one list action per beat.
`timescale 1ns / 1ps

interface ple_req_if import ple_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] item_value;
    logic [CNT_W-1:0]        position;

    modport source (output valid, action, item_value, position, input ready);
    modport sink (input valid, action, item_value, position, output ready);
endinterface

[rtl/ple_rsp_if.sv]
// Response channel interface: one result per beat.
`timescale 1ns / 1ps

interface ple_rsp_if import ple_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        found_position;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    list_empty;
    logic                    list_full;

    modport source (output valid, status, found_position, removed_value, entry_count,
                    list_empty, list_full, input ready);
    modport sink (input valid, status, found_position, removed_value, entry_count,
                  list_empty, list_full, output ready);
endinterface

[rtl/positional_list_engine.sv]
// Top level of the positional list engine: controller, datapath and assertions.
// Append and failed actions go straight to the result; insert and remove shift each entry
// after the position by a read and a write, and search compares entries from the first one
// until a match or the end of the list. The result waits in S_FIN while the output is busy.
// A new beat is taken only in idle, after the result of the last one has been registered.
// Reset clears the count and the result valid; entry contents are not cleared.
`timescale 1ns / 1ps

module positional_list_engine import ple_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    ple_req_if.sink    i_req,
    ple_rsp_if.source  o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    ple_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_req.action),
        .i_item_value     (i_req.item_value),
        .i_position       (i_req.position),
        .i_out_ready      (o_rsp.ready),
        .o_stat           (stat),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_found_position (o_rsp.found_position),
        .o_removed_value  (o_rsp.removed_value),
        .o_entry_count    (o_rsp.entry_count),
        .o_list_empty     (o_rsp.list_empty),
        .o_list_full      (o_rsp.list_full)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.entry_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found_position != '0) |-> o_rsp.status == ST_OK)
        else $error("A found position was reported with a failing status.");

    a_fail_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> o_rsp.removed_value == '0)
        else $error("A removed value was reported with a failing status.");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !i_req.ready)
        else $error("A new beat was taken while an action was in progress.");

endmodule

[rtl/ple_ctrl.sv]
// Controller state machine that sequences each list action over the entry memory.
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_TAKE = 8'b0000_0100,
        S_CHK  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_WR   = 8'b0010_0000,
        S_PUT  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.err) begin
                    n_state = S_FIN;
                end else begin
                    case (i_stat.act)
                        ACT_APPEND: n_state = S_FIN;
                        ACT_INSERT: n_state = S_CHK;
                        ACT_REMOVE: n_state = S_TAKE;
                        ACT_SEARCH: n_state = S_CHK;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_TAKE: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.more) begin
                    n_state = S_RD;
                end else if (i_stat.act == ACT_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if (i_stat.act == ACT_SEARCH && i_stat.hit) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_PUT: n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.take = (r_state == S_TAKE);
    assign o_cmd.rd   = (r_state == S_RD);
    assign o_cmd.wr   = (r_state == S_WR);
    assign o_cmd.put  = (r_state == S_PUT);
    assign o_cmd.fin  = (r_state == S_FIN) && i_stat.out_free;

endmodule

[rtl/ple_dp.sv]
// Datapath: entry memory, count, index counter, checks and the result register.
`timescale 1ns / 1ps

module ple_dp import ple_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [ACT_W-1:0] i_action,
    input  logic [VAL_W-1:0] i_item_value,
    input  logic [CNT_W-1:0] i_position,
    input  logic             i_out_ready,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_found_position,
    output logic [VAL_W-1:0] o_removed_value,
    output logic [CNT_W-1:0] o_entry_count,
    output logic             o_list_empty,
    output logic             o_list_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    t_action          r_act;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx;
    t_status          r_status;
    logic [CNT_W-1:0] r_found;
    logic [VAL_W-1:0] r_removed;

    logic             r_o_vld;
    t_status          r_o_status;
    logic [CNT_W-1:0] r_o_found;
    logic [VAL_W-1:0] r_o_removed;
    logic [CNT_W-1:0] r_o_cnt;

    logic             full;
    logic             empty;
    logic [CNT_W-1:0] pos_m1;
    t_status          exec_st;
    logic [CNT_W-1:0] n_cnt;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [VAL_W-1:0] wr_data;
    logic             hit;
    logic             more;

    assign full   = (r_cnt == CNT_W'(DEPTH));
    assign empty  = (r_cnt == '0);
    assign pos_m1 = r_pos - CNT_W'(1);
    assign hit    = (r_rdata == r_val);

    always_comb begin
        case (r_act)
            ACT_APPEND: exec_st = full ? ST_FULL : ST_OK;
            ACT_INSERT: begin
                if (full) begin
                    exec_st = ST_FULL;
                end else if (r_pos == '0 || r_pos > r_cnt + CNT_W'(1)) begin
                    exec_st = ST_BADPOS;
                end else begin
                    exec_st = ST_OK;
                end
            end
            ACT_REMOVE: begin
                if (empty) begin
                    exec_st = ST_EMPTY;
                end else if (r_pos == '0 || r_pos > r_cnt) begin
                    exec_st = ST_BADPOS;
                end else begin
                    exec_st = ST_OK;
                end
            end
            default: exec_st = ST_NOTFOUND;
        endcase
    end

    always_comb begin
        case (r_act)
            ACT_INSERT: more = (r_idx > pos_m1);
            ACT_REMOVE: more = (r_idx + CNT_W'(1) < r_cnt);
            ACT_SEARCH: more = (r_idx < r_cnt);
            default:    more = 1'b0;
        endcase
    end

    assign o_stat.act      = r_act;
    assign o_stat.err      = (exec_st != ST_OK) && (r_act != ACT_SEARCH);
    assign o_stat.more     = more;
    assign o_stat.hit      = hit;
    assign o_stat.out_free = !r_o_vld || i_out_ready;

    always_comb begin
        rd_en  = i_cmd.rd || (i_cmd.exec && r_act == ACT_REMOVE);
        rd_idx = r_idx;
        if (i_cmd.exec) begin
            rd_idx = pos_m1;
        end else begin
            case (r_act)
                ACT_INSERT: rd_idx = r_idx - CNT_W'(1);
                ACT_REMOVE: rd_idx = r_idx + CNT_W'(1);
                default:    rd_idx = r_idx;
            endcase
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_idx;
        wr_data = r_rdata;
        if (i_cmd.exec && r_act == ACT_APPEND && exec_st == ST_OK) begin
            wr_en   = 1'b1;
            wr_idx  = r_cnt;
            wr_data = r_val;
        end else if (i_cmd.wr && r_act != ACT_SEARCH) begin
            wr_en = 1'b1;
        end else if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_idx  = pos_m1;
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_idx[AW-1:0]];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_status == ST_OK) begin
            case (r_act)
                ACT_APPEND: n_cnt = r_cnt + CNT_W'(1);
                ACT_INSERT: n_cnt = r_cnt + CNT_W'(1);
                ACT_REMOVE: n_cnt = r_cnt - CNT_W'(1);
                default:    n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_val <= i_item_value;
            r_pos <= i_position;
        end
        if (i_cmd.exec) begin
            r_status  <= exec_st;
            r_found   <= '0;
            r_removed <= '0;
            r_idx     <= (r_act == ACT_INSERT) ? r_cnt : '0;
        end
        if (i_cmd.take) begin
            r_removed <= r_rdata;
            r_idx     <= pos_m1;
        end
        if (i_cmd.wr) begin
            case (r_act)
                ACT_INSERT: r_idx <= r_idx - CNT_W'(1);
                ACT_REMOVE: r_idx <= r_idx + CNT_W'(1);
                default: begin
                    if (hit) begin
                        r_found  <= r_idx + CNT_W'(1);
                        r_status <= ST_OK;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
            endcase
        end
        if (i_cmd.fin) begin
            r_o_status  <= r_status;
            r_o_found   <= r_found;
            r_o_removed <= r_removed;
            r_o_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_cnt   <= n_cnt;
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_removed_value  = r_o_removed;
    assign o_entry_count    = r_o_cnt;
    assign o_list_empty     = (r_o_cnt == '0);
    assign o_list_full      = (r_o_cnt == CNT_W'(DEPTH));

endmodule

[test/tb.sv]
// Self-checking testbench that drives directed and random list actions and checks every result beat.
`timescale 1ns / 1ps

module tb;
    import ple_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_ACTIONS = 1330;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 250;
    localparam int CYCLE_LIMIT    = 2_000_000;

    typedef enum {GROW, SHRINK, MIXED} t_trend;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] found;
        logic [VAL_W-1:0] removed;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } t_list_result;

    class list_mirror;
        int               depth;
        logic [VAL_W-1:0] entries[$];
        t_list_result     pending_results[$];
        int               errors;
        int               checked;
        int               status_seen[5];
        int               fills;
        int               empties;

        function new(int depth);
            this.depth = depth;
        endfunction

        function void apply_action(t_action act, logic [VAL_W-1:0] val,
                                   logic [CNT_W-1:0] pos);
            t_list_result r;
            int           cnt;
            cnt = entries.size();
            r.status  = ST_OK;
            r.found   = '0;
            r.removed = '0;
            case (act)
                ACT_APPEND: begin
                    if (cnt >= depth) r.status = ST_FULL;
                    else entries.push_back(val);
                end
                ACT_INSERT: begin
                    if (cnt >= depth) r.status = ST_FULL;
                    else if (pos < 1 || pos > cnt + 1) r.status = ST_BADPOS;
                    else entries.insert(pos - 1, val);
                end
                ACT_REMOVE: begin
                    if (cnt == 0) begin
                        r.status = ST_EMPTY;
                    end else if (pos < 1 || pos > cnt) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.removed = entries[pos - 1];
                        entries.delete(pos - 1);
                    end
                end
                default: begin
                    r.status = ST_NOTFOUND;
                    foreach (entries[i]) begin
                        if (r.status == ST_NOTFOUND && entries[i] == val) begin
                            r.status = ST_OK;
                            r.found  = CNT_W'(i + 1);
                        end
                    end
                end
            endcase
            r.count = CNT_W'(entries.size());
            r.empty = (entries.size() == 0);
            r.full  = (entries.size() == depth);
            if (r.full && cnt < depth) fills++;
            if (r.empty && cnt > 0) empties++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want,
                                    logic [VAL_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no action waiting for it");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            compare_field("status", VAL_W'(want.status), VAL_W'(got.status));
            compare_field("found_position", VAL_W'(want.found), VAL_W'(got.found));
            compare_field("removed_value", want.removed, got.removed);
            compare_field("entry_count", VAL_W'(want.count), VAL_W'(got.count));
            compare_field("list_empty", VAL_W'(want.empty), VAL_W'(got.empty));
            compare_field("list_full", VAL_W'(want.full), VAL_W'(got.full));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idle_on;
    int   hold_requests;
    int   cycle_count;
    int   actions_sent;

    list_mirror mirror = new(LIST_DEPTH);

    ple_req_if req_if ();
    ple_rsp_if rsp_if ();

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_req(req_if),
        .o_rsp(rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_action(t_action act, logic [VAL_W-1:0] val, logic [CNT_W-1:0] pos);
        while (idle_on && $urandom_range(99) < 32) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.item_value <= val;
        req_if.position   <= pos;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        mirror.apply_action(act, val, pos);
        actions_sent++;
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (mirror.pending_results.size() != 0);
    endtask

    function automatic void make_action(input t_trend trend, output t_action act,
                                        output logic [VAL_W-1:0] val,
                                        output logic [CNT_W-1:0] pos);
        int cnt;
        int r;
        int add_w;
        int rem_w;
        cnt = mirror.entries.size();
        case (trend)
            GROW: begin
                add_w = 65;
                rem_w = 20;
            end
            SHRINK: begin
                add_w = 20;
                rem_w = 65;
            end
            default: begin
                add_w = 40;
                rem_w = 40;
            end
        endcase
        r = $urandom_range(99);
        if (r < add_w) act = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
        else if (r < add_w + rem_w) act = ACT_REMOVE;
        else act = ACT_SEARCH;

        // A small pool of values makes duplicates, so search must report the first match.
        r = $urandom_range(3);
        if (r == 0) val = $urandom_range(8) - 4;
        else if (r == 1 && cnt > 0) val = mirror.entries[$urandom_range(cnt - 1)];
        else val = $urandom;

        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: pos = '0;
                1: pos = (act == ACT_INSERT) ? CNT_W'(cnt + 2) : CNT_W'(cnt + 1);
                2: pos = '1;
                default: pos = CNT_W'($urandom);
            endcase
        end else if (act == ACT_INSERT) begin
            pos = CNT_W'($urandom_range(cnt + 1, 1));
        end else if (act == ACT_REMOVE && cnt > 0) begin
            pos = CNT_W'($urandom_range(cnt, 1));
        end else begin
            pos = CNT_W'($urandom);
        end
    endfunction

    task automatic run_directed();
        send_action(ACT_SEARCH, 32'h0000_0000, 7'd0);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd1);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd0);
        send_action(ACT_INSERT, 32'h0000_0001, 7'd0);
        send_action(ACT_INSERT, 32'h0000_0001, 7'd2);
        send_action(ACT_INSERT, 32'h8000_0000, 7'd1);
        send_action(ACT_APPEND, 32'h7FFF_FFFF, 7'd0);
        send_action(ACT_APPEND, 32'hFFFF_FFFF, 7'd127);
        send_action(ACT_APPEND, 32'h0000_0000, 7'd0);
        send_action(ACT_INSERT, 32'h5555_5555, 7'd5);
        send_action(ACT_INSERT, 32'hAAAA_AAAA, 7'd1);
        send_action(ACT_APPEND, 32'h7FFF_FFFF, 7'd0);
        send_action(ACT_SEARCH, 32'h7FFF_FFFF, 7'd0);
        send_action(ACT_SEARCH, 32'h8000_0000, 7'd127);
        send_action(ACT_SEARCH, 32'h1234_5678, 7'd0);
        send_action(ACT_INSERT, 32'h0000_0001, 7'd9);
        send_action(ACT_INSERT, 32'h0000_0001, 7'd127);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd0);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd8);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd127);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd1);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd6);
        send_action(ACT_REMOVE, 32'h0000_0000, 7'd3);
    endtask

    initial begin : result_sink
        int           hold_left;
        int           holds_served;
        t_list_result got;
        hold_left    = 0;
        holds_served = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                got.status  = rsp_if.status;
                got.found   = rsp_if.found_position;
                got.removed = rsp_if.removed_value;
                got.count   = rsp_if.entry_count;
                got.empty   = rsp_if.list_empty;
                got.full    = rsp_if.list_full;
                mirror.check_result(got);
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(idle_on && $urandom_range(99) < 32);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_trend           trend;
        t_action          act;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] pos;
        int               cnt;
        int               extreme_hits;
        int               mixed_left;
        req_if.valid      <= 1'b0;
        req_if.action     <= ACT_APPEND;
        req_if.item_value <= '0;
        req_if.position   <= '0;
        rst_n             <= 1'b0;
        idle_on           <= 1'b1;
        hold_requests     <= 0;
        actions_sent = 0;
        trend        = GROW;
        extreme_hits = 0;
        mixed_left   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_for_results();

        for (int n = 0; n < RANDOM_ACTIONS; n++) begin
            if (n == 350) hold_requests <= hold_requests + 1;
            if (n == 600) idle_on <= 1'b0;
            if (n == 800) idle_on <= 1'b1;
            if (n == 1000) wait_for_results();
            make_action(trend, act, val, pos);
            send_action(act, val, pos);

            cnt = mirror.entries.size();
            if (trend == MIXED) begin
                mixed_left--;
                if (mixed_left <= 0) trend = GROW;
            end else if ((trend == GROW && cnt == LIST_DEPTH) ||
                         (trend == SHRINK && cnt == 0)) begin
                extreme_hits++;
                if (extreme_hits > 6) begin
                    extreme_hits = 0;
                    if (trend == GROW) begin
                        trend = SHRINK;
                    end else if ($urandom_range(2) == 0) begin
                        trend      = MIXED;
                        mixed_left = 80;
                    end else begin
                        trend = GROW;
                    end
                end
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d actions and checked %0d results: %0d ok, %0d full, %0d empty,",
                 actions_sent, mirror.checked, mirror.status_seen[ST_OK],
                 mirror.status_seen[ST_FULL], mirror.status_seen[ST_EMPTY]);
        $display("%0d bad position and %0d not found; the list filled to %0d entries %0d times.",
                 mirror.status_seen[ST_BADPOS], mirror.status_seen[ST_NOTFOUND],
                 LIST_DEPTH, mirror.fills);
        if (mirror.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
